@@ sv/tlshr_pkg.sv @@
// Shared constants, code tables and helper functions for the TLS hello list randomizer.
// No dependencies; imported by tls_hello_list_randomizer.
package tlshr_pkg;

  localparam int unsigned BUF_DEPTH = 14;
  localparam int unsigned BUF_AW    = 4;

  localparam logic [63:0] SEED_DEFAULT = 64'h0000_0000_7E50_FEED;
  localparam logic [15:0] GREASE_BASE  = 16'h0A0A;
  localparam logic [15:0] EXT_TICKET   = 16'h0023;
  localparam logic [15:0] EXT_PSK      = 16'h0029;
  localparam logic [15:0] EXT_PADDING  = 16'h0015;
  localparam logic [15:0] GRP_X25519   = 16'h001D;
  localparam logic [15:0] GRP_P256     = 16'h0017;
  localparam logic [15:0] GRP_P384     = 16'h0018;
  localparam logic [15:0] VER_TLS13    = 16'h0304;
  localparam logic [15:0] VER_TLS12    = 16'h0303;
  localparam logic [15:0] CERT_BROTLI  = 16'h0002;
  localparam logic [15:0] PSK_DHE      = 16'h0001;
  localparam logic [15:0] WORD_ZERO    = 16'h0000;

  // list tags
  localparam logic [3:0] LID_GREASE = 4'd0;
  localparam logic [3:0] LID_CIPHER = 4'd1;
  localparam logic [3:0] LID_EXT    = 4'd2;
  localparam logic [3:0] LID_GROUP  = 4'd3;
  localparam logic [3:0] LID_SIGALG = 4'd4;
  localparam logic [3:0] LID_PTFMT  = 4'd5;
  localparam logic [3:0] LID_PSK    = 4'd6;
  localparam logic [3:0] LID_VER    = 4'd7;
  localparam logic [3:0] LID_CERT   = 4'd8;

  // register indexes
  localparam logic [2:0] CFG_PROFILE = 3'd0;
  localparam logic [2:0] CFG_DROP    = 3'd1;
  localparam logic [2:0] CFG_GREASE  = 3'd2;
  localparam logic [2:0] CFG_TICKET  = 3'd3;
  localparam logic [2:0] CFG_PADDING = 3'd4;

  localparam logic [6:0] OPT_MODULUS = 7'd100;
  localparam logic [6:0] OPT_THRESH  = 7'd40;
  localparam logic [2:0] OPT_COUNT   = 3'd6;

  typedef enum logic [1:0] {
    FILL_T13,
    FILL_T12,
    FILL_EXT,
    FILL_SIG
  } fill_sel_e;

  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] a;
    logic [63:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 7);
    return b ^ (b << 17);
  endfunction

  function automatic logic [15:0] fill_word(input fill_sel_e sel, input logic [3:0] i);
    logic [15:0] w;
    w = WORD_ZERO;
    case (sel)
      FILL_T13: begin
        case (i)
          4'd0: w = 16'h1301;
          4'd1: w = 16'h1302;
          default: w = 16'h1303;
        endcase
      end
      FILL_T12: begin
        case (i)
          4'd0: w = 16'hC02B;
          4'd1: w = 16'hC02F;
          4'd2: w = 16'hC02C;
          4'd3: w = 16'hC030;
          4'd4: w = 16'hCCA9;
          default: w = 16'hCCA8;
        endcase
      end
      FILL_EXT: begin
        case (i)
          4'd0:  w = 16'h0017;
          4'd1:  w = 16'hFF01;
          4'd2:  w = 16'h000A;
          4'd3:  w = 16'h000B;
          4'd4:  w = 16'h0023;
          4'd5:  w = 16'h0010;
          4'd6:  w = 16'h0005;
          4'd7:  w = 16'h000D;
          4'd8:  w = 16'h002B;
          4'd9:  w = 16'h002D;
          4'd10: w = 16'h0033;
          4'd11: w = 16'h001B;
          4'd12: w = 16'h0012;
          default: w = 16'h0039;
        endcase
      end
      default: begin
        case (i)
          4'd0: w = 16'h0403;
          4'd1: w = 16'h0804;
          4'd2: w = 16'h0401;
          4'd3: w = 16'h0503;
          4'd4: w = 16'h0805;
          4'd5: w = 16'h0501;
          4'd6: w = 16'h0806;
          default: w = 16'h0601;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic [15:0] opt_word(input logic [2:0] i);
    logic [15:0] w;
    case (i)
      3'd0: w = 16'h001C;
      3'd1: w = 16'h0015;
      3'd2: w = 16'h0029;
      3'd3: w = 16'h002C;
      3'd4: w = 16'h0031;
      default: w = 16'h0011;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] group_opt(input logic [2:0] i);
    logic [15:0] w;
    case (i)
      3'd0: w = 16'h0019;
      3'd1: w = 16'h001E;
      default: w = 16'h0100;
    endcase
    return w;
  endfunction

endpackage

@@ sv/tls_hello_list_randomizer.sv @@
// TLS hello list randomizer: top level, sequencer, shared modulo unit and output register.
// Depends on tlshr_pkg and tlshr_ram.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / session_seed_i): one beat is one
//    session seed. in_stall_o is high from acceptance until the last word of that
//    seed has been loaded into the output register.
//  - Output channel (out_valid_o / out_stall_i): one beat per tagged word
//    (list_id_o, code_word_o, list_end_o, run_end_o). run_end_o marks the last
//    word of the seed. A stalled word holds; the sequencer waits on it.
//  - Config channel (cfg_valid_i / cfg_ready_o): always ready, write only while
//    idle. Unknown indexes are dropped.
//  - Run time: set by the shared modulo unit, which folds 4 bits of a 64-bit
//    draw per cycle (18 to 23 range draws per seed), plus the swap through the
//    single read port of the shuffle RAM and the RAM read ahead of each
//    RAM-sourced output word. Output stalls add to it.
//  - Reset: config registers take their reset values, sequencer returns to
//    idle, output register empties, GREASE picks clear to zero. Shuffle RAM holds
//    garbage until a seed writes it; every read follows a write.
module tls_hello_list_randomizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] session_seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  list_id_o,
  output logic [15:0] code_word_o,
  output logic        list_end_o,
  output logic        run_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i
);
  import tlshr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_GR_DRAW, S_GR_EMIT, S_DISP, S_FILL, S_SH, S_MOD,
    S_SW0, S_SW1, S_SW2, S_SW3, S_PR, S_ER_RD, S_ER_EM, S_EXH,
    S_OPT, S_OPT_EM, S_EXT, S_GPB, S_GPF, S_TAIL
  } state_e;

  // work program walked by the dispatcher
  typedef enum logic [4:0] {
    P_CI13_FILL, P_CI13_SHUF, P_CI13_EM,
    P_CI12_FILL, P_CI12_PAIR, P_CI12_EM,
    P_EX_HEAD, P_EX_FILL, P_EX_SHUF, P_EX_EM, P_EX_OPT, P_EX_TAIL,
    P_GP_B, P_GP_SHUF, P_GP_F, P_GP_EM,
    P_SG_FILL, P_SG_PAIR, P_SG_EM,
    P_TAIL
  } step_e;

  // config registers
  logic       profile_q;
  logic [1:0] drop_q;
  logic [2:0] gcount_q;
  logic       ticket_q;
  logic       pad_q;

  // sequencer
  state_e     state_q;
  step_e      step_q;
  logic [63:0] prng_q;
  logic [15:0] gp_q [4];
  logic [2:0] c_q;
  logic [3:0] si_q, wi_q, flen_q, idx_q, sh_i_q, hi_q, j_q, er_cnt_q;
  logic [2:0] p_q, np_q, oi_q;
  fill_sel_e  fsel_q;
  logic       pm_q, om_q, vf_q, er_last_q;
  logic [3:0] er_id_q;
  logic [15:0] tmp_q;

  // modulo unit
  logic [63:0] md_q;
  logic [6:0]  rem_q, rem_nx, div_q;
  logic [3:0]  mc_q;

  // output register
  logic        ov_q, le_q, re_q;
  logic [3:0]  lid_q;
  logic [15:0] cw_q;

  // derived
  logic [2:0]  g_eff;
  logic [1:0]  drop_eff;
  logic        ticket_eff, pad_eff;
  logic [63:0] dnext;
  logic        dbool;
  logic [15:0] gval, fword, oword;
  logic        dup, fskip, oskip;

  logic        em_fire, em_le, em_re, em_go, can_load;
  logic [3:0]  em_id;
  logic [15:0] em_word;

  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;

  // effective settings; base variant ignores the registers
  always_comb begin
    if (profile_q) begin
      if (gcount_q < 3'd2)      g_eff = 3'd2;
      else if (gcount_q > 3'd4) g_eff = 3'd4;
      else                      g_eff = gcount_q;
      drop_eff   = drop_q;
      ticket_eff = ticket_q;
      pad_eff    = pad_q;
    end else begin
      g_eff      = 3'd3;
      drop_eff   = 2'd0;
      ticket_eff = 1'b1;
      pad_eff    = 1'b0;
    end
  end

  assign dnext = xorshift(prng_q);
  assign dbool = ~dnext[0];
  assign gval  = {dnext[3:0], 4'h0, dnext[3:0], 4'h0} + GREASE_BASE;
  assign fword = fill_word(fsel_q, si_q);
  assign fskip = (fsel_q == FILL_EXT) && (fword == EXT_TICKET) && !ticket_eff;
  assign oword = opt_word(oi_q);
  assign oskip = profile_q && ((oword == EXT_PADDING) || ((oword == EXT_PSK) && !ticket_eff));

  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((3'(k) < c_q) && (gp_q[k] == gval)) dup = 1'b1;
    end
  end

  // modulo step: four restoring subtract steps per cycle, MSB first
  always_comb begin
    logic [7:0] t;
    logic [6:0] r;
    r = rem_q;
    for (int k = 0; k < 4; k++) begin
      t = {r, md_q[63-k]};
      if (t >= {1'b0, div_q}) t = t - {1'b0, div_q};
      r = t[6:0];
    end
    rem_nx = r;
  end

  // what the current state wants to emit, and RAM port control
  always_comb begin
    em_fire   = 1'b0;
    em_id     = LID_GREASE;
    em_word   = WORD_ZERO;
    em_le     = 1'b0;
    em_re     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wi_q;
    ram_wdata = fword;
    ram_raddr = idx_q;
    case (state_q)
      S_GR_EMIT: begin
        em_fire = 1'b1;
        if (c_q == g_eff) begin
          // cipher list opens with the first pick
          em_id   = LID_CIPHER;
          em_word = gp_q[0];
        end else begin
          em_word = gp_q[c_q[1:0]];
          em_le   = (c_q == g_eff - 3'd1);
        end
      end
      S_FILL: ram_we = !fskip;
      S_SW0:  ram_raddr = hi_q;
      S_SW1:  ram_raddr = j_q;
      S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = ram_rdata;
      end
      S_SW3: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = tmp_q;
      end
      S_ER_EM: begin
        em_fire = 1'b1;
        em_id   = er_id_q;
        em_word = ram_rdata;
        em_le   = er_last_q && (idx_q == er_cnt_q - 4'd1);
      end
      S_EXH: begin
        em_fire = 1'b1;
        em_id   = LID_EXT;
        em_word = (c_q == 3'd0) ? gp_q[1] : WORD_ZERO;
      end
      S_OPT_EM: begin
        em_fire = (rem_q < OPT_THRESH);
        em_id   = LID_EXT;
        em_word = oword;
      end
      S_EXT: begin
        em_id = LID_EXT;
        if (c_q == 3'd0) begin
          em_fire = pad_eff;
          em_word = EXT_PADDING;
        end else begin
          em_fire = 1'b1;
          em_word = gp_q[2'(g_eff - 3'd1)];
          em_le   = 1'b1;
        end
      end
      S_GPB: begin
        ram_we    = dbool;
        ram_wdata = group_opt(c_q);
      end
      S_GPF: begin
        em_fire = 1'b1;
        em_id   = LID_GROUP;
        case (c_q)
          3'd0:    em_word = gp_q[0];
          3'd1:    em_word = GRP_X25519;
          3'd2:    em_word = GRP_P256;
          default: em_word = GRP_P384;
        endcase
        // with no optional group drawn, P-384 closes the list
        em_le = (c_q == 3'd3) && (wi_q == 4'd0);
      end
      S_TAIL: begin
        em_fire = (c_q != 3'd3);
        case (c_q)
          3'd0: begin
            em_id = LID_PTFMT; em_word = WORD_ZERO; em_le = 1'b1;
          end
          3'd1: begin
            em_id = LID_PSK; em_word = PSK_DHE; em_le = 1'b1;
          end
          3'd2: begin
            em_id = LID_VER; em_word = gp_q[1];
          end
          3'd4: begin
            em_id = LID_VER; em_word = vf_q ? VER_TLS13 : VER_TLS12;
          end
          3'd5: begin
            em_id = LID_VER; em_word = vf_q ? VER_TLS12 : VER_TLS13; em_le = 1'b1;
          end
          3'd6: begin
            em_id = LID_CERT; em_word = CERT_BROTLI; em_le = 1'b1; em_re = 1'b1;
          end
          default: em_id = LID_VER;
        endcase
      end
      default: ;
    endcase
  end

  assign can_load = !ov_q || !out_stall_i;
  assign em_go    = em_fire && can_load;

  tlshr_ram #(
    .Width(16),
    .Depth(BUF_DEPTH)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_q <= 1'b0;
      drop_q    <= 2'd0;
      gcount_q  <= 3'd3;
      ticket_q  <= 1'b1;
      pad_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROFILE: profile_q <= cfg_data_i[0];
        CFG_DROP:    drop_q    <= cfg_data_i[1:0];
        CFG_GREASE:  gcount_q  <= cfg_data_i;
        CFG_TICKET:  ticket_q  <= cfg_data_i[0];
        CFG_PADDING: pad_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer, modulo unit and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= P_CI13_FILL;
      prng_q    <= '0;
      for (int k = 0; k < 4; k++) gp_q[k] <= '0;
      c_q       <= '0;
      si_q      <= '0;
      wi_q      <= '0;
      flen_q    <= '0;
      idx_q     <= '0;
      sh_i_q    <= '0;
      hi_q      <= '0;
      j_q       <= '0;
      er_cnt_q  <= '0;
      p_q       <= '0;
      np_q      <= '0;
      oi_q      <= '0;
      fsel_q    <= FILL_T13;
      pm_q      <= 1'b0;
      om_q      <= 1'b0;
      vf_q      <= 1'b0;
      er_last_q <= 1'b0;
      er_id_q   <= LID_CIPHER;
      tmp_q     <= '0;
      md_q      <= '0;
      rem_q     <= '0;
      div_q     <= 7'd1;
      mc_q      <= '0;
      ov_q      <= 1'b0;
      le_q      <= 1'b0;
      re_q      <= 1'b0;
      lid_q     <= LID_GREASE;
      cw_q      <= '0;
    end else begin
      if (em_go) begin
        ov_q  <= 1'b1;
        lid_q <= em_id;
        cw_q  <= em_word;
        le_q  <= em_le;
        re_q  <= em_re;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            prng_q  <= (session_seed_i == '0) ? SEED_DEFAULT : session_seed_i;
            c_q     <= '0;
            state_q <= S_GR_DRAW;
          end
        end
        S_GR_DRAW: begin
          prng_q <= dnext;
          if (!dup) begin
            gp_q[c_q[1:0]] <= gval;
            if (c_q == g_eff - 3'd1) begin
              c_q     <= '0;
              state_q <= S_GR_EMIT;
            end else begin
              c_q <= c_q + 3'd1;
            end
          end
        end
        S_GR_EMIT: begin
          if (em_go) begin
            if (c_q == g_eff) begin
              step_q  <= P_CI13_FILL;
              state_q <= S_DISP;
            end else begin
              c_q <= c_q + 3'd1;
            end
          end
        end
        S_DISP: begin
          step_q <= step_e'(5'(step_q) + 5'd1);
          case (step_q)
            P_CI13_FILL, P_CI12_FILL, P_EX_FILL, P_SG_FILL: begin
              si_q    <= '0;
              wi_q    <= '0;
              state_q <= S_FILL;
              case (step_q)
                P_CI13_FILL: begin fsel_q <= FILL_T13; flen_q <= 4'd3;  end
                P_CI12_FILL: begin fsel_q <= FILL_T12; flen_q <= 4'd6;  end
                P_EX_FILL:   begin fsel_q <= FILL_EXT; flen_q <= 4'd14; end
                default:     begin fsel_q <= FILL_SIG; flen_q <= 4'd8;  end
              endcase
            end
            P_CI13_SHUF, P_EX_SHUF, P_GP_SHUF: begin
              sh_i_q  <= wi_q;
              pm_q    <= 1'b0;
              state_q <= S_SH;
            end
            P_CI12_PAIR, P_SG_PAIR: begin
              p_q     <= '0;
              np_q    <= (step_q == P_CI12_PAIR) ? 3'd3 : 3'd4;
              state_q <= S_PR;
            end
            P_CI13_EM, P_CI12_EM, P_EX_EM, P_GP_EM, P_SG_EM: begin
              idx_q <= '0;
              case (step_q)
                P_CI13_EM: begin er_id_q <= LID_CIPHER; er_last_q <= 1'b0; end
                P_CI12_EM: begin er_id_q <= LID_CIPHER; er_last_q <= 1'b1; end
                P_EX_EM:   begin er_id_q <= LID_EXT;    er_last_q <= 1'b0; end
                P_GP_EM:   begin er_id_q <= LID_GROUP;  er_last_q <= 1'b1; end
                default:   begin er_id_q <= LID_SIGALG; er_last_q <= 1'b1; end
              endcase
              if (step_q == P_CI12_EM) begin
                er_cnt_q <= 4'd6 - {2'b00, drop_eff};
                state_q  <= S_ER_RD;
              end else begin
                er_cnt_q <= wi_q;
                state_q  <= (wi_q == 4'd0) ? S_DISP : S_ER_RD;
              end
            end
            P_EX_HEAD: begin c_q <= '0; state_q <= S_EXH; end
            P_EX_OPT:  begin oi_q <= '0; state_q <= S_OPT; end
            P_EX_TAIL: begin c_q <= '0; state_q <= S_EXT; end
            P_GP_B:    begin c_q <= '0; wi_q <= '0; state_q <= S_GPB; end
            P_GP_F:    begin c_q <= '0; state_q <= S_GPF; end
            default:   begin c_q <= '0; state_q <= S_TAIL; end
          endcase
        end
        S_FILL: begin
          if (!fskip) wi_q <= wi_q + 4'd1;
          si_q <= si_q + 4'd1;
          if (si_q == flen_q - 4'd1) state_q <= S_DISP;
        end
        S_SH: begin
          if (sh_i_q <= 4'd1) begin
            state_q <= S_DISP;
          end else begin
            prng_q  <= dnext;
            md_q    <= dnext;
            rem_q   <= '0;
            mc_q    <= '0;
            div_q   <= {3'b000, sh_i_q};
            om_q    <= 1'b0;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          rem_q <= rem_nx;
          md_q  <= md_q << 4;
          mc_q  <= mc_q + 4'd1;
          if (mc_q == 4'd15) begin
            hi_q    <= sh_i_q - 4'd1;
            j_q     <= rem_nx[3:0];
            state_q <= om_q ? S_OPT_EM : S_SW0;
          end
        end
        S_SW0: state_q <= S_SW1;
        S_SW1: begin
          tmp_q   <= ram_rdata;
          state_q <= S_SW2;
        end
        S_SW2: state_q <= S_SW3;
        S_SW3: begin
          if (pm_q) begin
            state_q <= S_PR;
          end else begin
            sh_i_q  <= sh_i_q - 4'd1;
            state_q <= S_SH;
          end
        end
        S_PR: begin
          if (p_q == np_q) begin
            state_q <= S_DISP;
          end else begin
            prng_q <= dnext;
            p_q    <= p_q + 3'd1;
            if (dbool) begin
              hi_q    <= {p_q, 1'b0};
              j_q     <= {p_q, 1'b1};
              pm_q    <= 1'b1;
              state_q <= S_SW0;
            end
          end
        end
        S_ER_RD: state_q <= S_ER_EM;
        S_ER_EM: begin
          if (em_go) begin
            if (idx_q == er_cnt_q - 4'd1) begin
              state_q <= S_DISP;
            end else begin
              idx_q   <= idx_q + 4'd1;
              state_q <= S_ER_RD;
            end
          end
        end
        S_EXH: begin
          if (em_go) begin
            if (c_q == 3'd1) state_q <= S_DISP;
            else             c_q <= c_q + 3'd1;
          end
        end
        S_OPT: begin
          if (oi_q == OPT_COUNT) begin
            state_q <= S_DISP;
          end else if (oskip) begin
            oi_q <= oi_q + 3'd1;
          end else begin
            prng_q  <= dnext;
            md_q    <= dnext;
            rem_q   <= '0;
            mc_q    <= '0;
            div_q   <= OPT_MODULUS;
            om_q    <= 1'b1;
            state_q <= S_MOD;
          end
        end
        S_OPT_EM: begin
          if (!em_fire || em_go) begin
            oi_q    <= oi_q + 3'd1;
            state_q <= S_OPT;
          end
        end
        S_EXT: begin
          if (c_q == 3'd0) begin
            if (!em_fire || em_go) c_q <= 3'd1;
          end else if (em_go) begin
            state_q <= S_DISP;
          end
        end
        S_GPB: begin
          prng_q <= dnext;
          if (dbool) wi_q <= wi_q + 4'd1;
          if (c_q == 3'd2) state_q <= S_DISP;
          else             c_q <= c_q + 3'd1;
        end
        S_GPF: begin
          if (em_go) begin
            if (c_q == 3'd3) state_q <= S_DISP;
            else             c_q <= c_q + 3'd1;
          end
        end
        S_TAIL: begin
          if (c_q == 3'd3) begin
            // version order draw
            prng_q <= dnext;
            vf_q   <= dbool;
            c_q    <= 3'd4;
          end else if (em_go) begin
            if (c_q == 3'd6) state_q <= S_IDLE;
            else             c_q <= c_q + 3'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign list_id_o   = lid_q;
  assign code_word_o = cw_q;
  assign list_end_o  = le_q;
  assign run_end_o   = re_q;

  // run end always closes a list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_end_o) |-> list_end_o)
    else $error("run end without list end");

  // modulo unit never runs with a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> (div_q != 7'd0))
    else $error("zero divisor in modulo unit");

  // shuffle RAM writes stay inside the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr < 4'(BUF_DEPTH)))
    else $error("shuffle buffer write out of range");

  // the first two GREASE picks are distinct once drawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GR_EMIT) |-> (gp_q[0] != gp_q[1]))
    else $error("duplicate GREASE pick");

  // a new seed is only taken after the previous run has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_go && em_re) |=> (state_q == S_IDLE))
    else $error("sequencer not idle after run end");

endmodule

@@ sv/tlshr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlshr_ram #(
  parameter int Width = 16,
  parameter int Depth = 14,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for tls_hello_list_randomizer: seeds in, tagged hello-list words out.
// Depends on tlshr_pkg and the block's RTL; predicts every word and checks it in order.
`timescale 1ns / 1ps

module testbench;
  import tlshr_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [3:0]  lid;
    logic [15:0] word;
    logic        lend;
    logic        rend;
  } hello_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] session_seed_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  list_id_o;
  logic [15:0] code_word_o;
  logic        list_end_o;
  logic        run_end_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [2:0]  cfg_data_i;

  tls_hello_list_randomizer u_dut (.*);

  // seeds waiting to go out, and words the block still owes us
  logic [63:0] seed_queue[$];
  hello_word_t owed_words[$];

  // mirror of the config registers
  logic       m_profile;
  logic [1:0] m_drop;
  logic [2:0] m_grease;
  logic       m_ticket;
  logic       m_padding;

  int  errors;
  bit  idle_on;
  int  in_gap;
  int  out_gap;
  int  quiet_cycles;

  // own copies of the code tables
  logic [15:0] t13_tab[3]  = '{16'h1301, 16'h1302, 16'h1303};
  logic [15:0] t12_tab[6]  = '{16'hC02B, 16'hC02F, 16'hC02C, 16'hC030, 16'hCCA9, 16'hCCA8};
  logic [15:0] ext_tab[14] = '{16'h0017, 16'hFF01, 16'h000A, 16'h000B, 16'h0023, 16'h0010,
                               16'h0005, 16'h000D, 16'h002B, 16'h002D, 16'h0033, 16'h001B,
                               16'h0012, 16'h0039};
  logic [15:0] opt_tab[6]  = '{16'h001C, 16'h0015, 16'h0029, 16'h002C, 16'h0031, 16'h0011};
  logic [15:0] sig_tab[8]  = '{16'h0403, 16'h0804, 16'h0401, 16'h0503,
                               16'h0805, 16'h0501, 16'h0806, 16'h0601};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // xorshift 13/7/17
  function automatic logic [63:0] prng_next(ref logic [63:0] s);
    s = s ^ (s << 13);
    s = s ^ (s >> 7);
    s = s ^ (s << 17);
    return s;
  endfunction

  // coin flip: true when the low bit of the next draw is clear
  function automatic bit prng_bool(ref logic [63:0] s);
    logic [63:0] r;
    r = prng_next(s);
    return (r[0] == 1'b0);
  endfunction

  // Fisher-Yates over the first n entries
  function automatic void fy_shuffle(ref logic [15:0] b[14], ref logic [63:0] s, input int n);
    logic [63:0] j;
    logic [15:0] t;
    for (int i = n; i > 1; i--) begin
      j = prng_next(s) % 64'(i);
      t = b[i-1];
      b[i-1] = b[j];
      b[j] = t;
    end
  endfunction

  function automatic void owe(input logic [3:0] lid, input logic [15:0] w);
    hello_word_t hw;
    hw = '{lid: lid, word: w, lend: 1'b0, rend: 1'b0};
    owed_words = {owed_words, hw};
  endfunction

  function automatic void close_list();
    owed_words[owed_words.size()-1].lend = 1'b1;
  endfunction

  // Expected word stream for one seed under the mirrored config.
  function automatic void predict_hello(input logic [63:0] seed);
    logic [63:0] s;
    logic [15:0] picks[4];
    logic [15:0] b[14];
    logic [15:0] v;
    logic [15:0] t;
    bit   dup;
    bit   prof;
    bit   ticket;
    bit   pad;
    bit   t13_first;
    int   g;
    int   drop;
    int   n;
    int   m;
    prof   = m_profile;
    g      = 3;
    drop   = 0;
    ticket = 1'b1;
    pad    = 1'b0;
    if (prof) begin
      g = m_grease;
      if (g < 2) g = 2;
      if (g > 4) g = 4;
      drop   = m_drop;
      ticket = m_ticket;
      pad    = m_padding;
    end
    s = (seed != 64'd0) ? seed : SEED_DEFAULT;

    // distinct GREASE values, redraw on repeat
    for (int i = 0; i < g; i++) begin
      do begin
        v = 16'((prng_next(s) % 64'd16) * 64'h1010) + GREASE_BASE;
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (picks[j] == v) dup = 1'b1;
      end while (dup);
      picks[i] = v;
    end
    for (int i = 0; i < g; i++) owe(LID_GREASE, picks[i]);
    close_list();

    owe(LID_CIPHER, picks[0]);
    for (int i = 0; i < 3; i++) b[i] = t13_tab[i];
    fy_shuffle(b, s, 3);
    for (int i = 0; i < 3; i++) owe(LID_CIPHER, b[i]);
    for (int i = 0; i < 6; i++) b[i] = t12_tab[i];
    for (int i = 0; i < 6; i += 2) begin
      if (prng_bool(s)) begin
        t = b[i]; b[i] = b[i+1]; b[i+1] = t;
      end
    end
    for (int i = 0; i < 6 - drop; i++) owe(LID_CIPHER, b[i]);
    close_list();

    owe(LID_EXT, picks[prof ? (1 % g) : 1]);
    owe(LID_EXT, WORD_ZERO);
    n = 0;
    for (int i = 0; i < 14; i++) begin
      if (ticket || ext_tab[i] != EXT_TICKET) begin
        b[n] = ext_tab[i];
        n++;
      end
    end
    fy_shuffle(b, s, n);
    for (int i = 0; i < n; i++) owe(LID_EXT, b[i]);
    for (int i = 0; i < 6; i++) begin
      if (prof && opt_tab[i] == EXT_PSK && !ticket) continue;
      if (prof && opt_tab[i] == EXT_PADDING) continue;
      if ((prng_next(s) % 64'd100) < 64'd40) owe(LID_EXT, opt_tab[i]);
    end
    if (pad) owe(LID_EXT, EXT_PADDING);
    owe(LID_EXT, picks[prof ? (g - 1) : 2]);
    close_list();

    owe(LID_GROUP, picks[0]);
    owe(LID_GROUP, GRP_X25519);
    owe(LID_GROUP, GRP_P256);
    owe(LID_GROUP, GRP_P384);
    m = 0;
    if (prng_bool(s)) begin b[m] = 16'h0019; m++; end
    if (prng_bool(s)) begin b[m] = 16'h001E; m++; end
    if (prng_bool(s)) begin b[m] = 16'h0100; m++; end
    fy_shuffle(b, s, m);
    for (int i = 0; i < m; i++) owe(LID_GROUP, b[i]);
    close_list();

    for (int i = 0; i < 8; i++) b[i] = sig_tab[i];
    for (int i = 0; i < 8; i += 2) begin
      if (prng_bool(s)) begin
        t = b[i]; b[i] = b[i+1]; b[i+1] = t;
      end
    end
    for (int i = 0; i < 8; i++) owe(LID_SIGALG, b[i]);
    close_list();

    owe(LID_PTFMT, WORD_ZERO);
    close_list();
    owe(LID_PSK, PSK_DHE);
    close_list();

    owe(LID_VER, picks[prof ? (1 % g) : 1]);
    t13_first = prng_bool(s);
    owe(LID_VER, t13_first ? VER_TLS13 : VER_TLS12);
    owe(LID_VER, t13_first ? VER_TLS12 : VER_TLS13);
    close_list();

    owe(LID_CERT, CERT_BROTLI);
    close_list();
    owed_words[owed_words.size()-1].rend = 1'b1;
  endfunction

  // Seed driver: payload only moves when the line is empty or the beat was taken.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) predict_hello(session_seed_i);
    if (!in_valid_i || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (rst_ni && seed_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        session_seed_i <= seed_queue.pop_front();
        if (idle_on && $urandom_range(0, 2) == 0) in_gap <= $urandom_range(1, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Word monitor plus random back-pressure bursts.
  always @(posedge clk_i) begin
    hello_word_t exp_w;
    if (out_valid_o && !out_stall_i) begin
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected beat lid=%0d word=%04h end=%b run=%b", $time,
                 list_id_o, code_word_o, list_end_o, run_end_o);
        errors++;
      end else begin
        exp_w = owed_words.pop_front();
        if (list_id_o !== exp_w.lid) begin
          $display("%0t: list_id expected %0d actual %0d", $time, exp_w.lid, list_id_o);
          errors++;
        end
        if (code_word_o !== exp_w.word) begin
          $display("%0t: code_word expected %04h actual %04h", $time, exp_w.word, code_word_o);
          errors++;
        end
        if (list_end_o !== exp_w.lend) begin
          $display("%0t: list_end expected %b actual %b", $time, exp_w.lend, list_end_o);
          errors++;
        end
        if (run_end_o !== exp_w.rend) begin
          $display("%0t: run_end expected %b actual %b", $time, exp_w.rend, run_end_o);
          errors++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (idle_on && $urandom_range(0, 15) == 0) out_gap <= $urandom_range(1, 14);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [2:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PROFILE: m_profile = data[0];
      CFG_DROP:    m_drop    = data[1:0];
      CFG_GREASE:  m_grease  = data;
      CFG_TICKET:  m_ticket  = data[0];
      CFG_PADDING: m_padding = data[0];
      default: ;
    endcase
  endtask

  task automatic set_profile(input logic [2:0] prof, input logic [2:0] drop,
                             input logic [2:0] grease, input logic [2:0] ticket,
                             input logic [2:0] pad);
    cfg_write(CFG_PROFILE, prof);
    cfg_write(CFG_DROP, drop);
    cfg_write(CFG_GREASE, grease);
    cfg_write(CFG_TICKET, ticket);
    cfg_write(CFG_PADDING, pad);
  endtask

  // Sender holds off until the block has delivered everything, then a
  // margin so the sequencer is back to idle before any register write.
  // Checked on the falling edge so every rising-edge update has settled.
  task automatic drain();
    while (seed_queue.size() != 0 || in_valid_i || owed_words.size() != 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_seeds(input int count);
    logic [63:0] sd;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0:       sd = 64'($urandom_range(0, 255));
        1:       sd = ~{$urandom, $urandom} | 64'h1;
        default: sd = {$urandom, $urandom};
      endcase
      seed_queue = {seed_queue, sd};
    end
  endtask

  task automatic add_seed(input logic [63:0] sd);
    seed_queue = {seed_queue, sd};
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    session_seed_i = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    m_profile = 1'b0;
    m_drop    = 2'd0;
    m_grease  = 3'd3;
    m_ticket  = 1'b1;
    m_padding = 1'b0;
    errors = 0;
    idle_on = 1'b1;
    in_gap = 0;
    out_gap = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config (base variant), seed extremes incl. zero default
    add_seed(64'd0);
    add_seed(64'd1);
    add_seed(64'hFFFF_FFFF_FFFF_FFFF);
    add_seed(64'h8000_0000_0000_0000);
    add_seed(64'h7E50_FEED);
    drain();

    // base variant ignores the rest of the registers
    set_profile(3'd0, 3'd3, 3'd7, 3'd0, 3'd1);
    add_seed(64'h0123_4567_89AB_CDEF);
    add_seed(64'd0);
    drain();

    // profile: grease clamps below 2, max drop, no ticket, padding
    set_profile(3'd1, 3'd3, 3'd0, 3'd0, 3'd1);
    add_seed(64'd0);
    add_seed(64'hFFFF_FFFF_FFFF_FFFF);
    add_seed(64'h5555_AAAA_5555_AAAA);
    drain();
    cfg_write(CFG_GREASE, 3'd1);
    // unknown indexes must be dropped
    cfg_write(3'd5, 3'd7);
    cfg_write(3'd6, 3'd0);
    cfg_write(3'd7, 3'd5);
    add_seed(64'hAAAA_5555_AAAA_5555);
    add_seed(64'd2);
    drain();

    // grease clamps above 4, ticket on, no padding
    set_profile(3'd1, 3'd0, 3'd7, 3'd1, 3'd0);
    add_seed(64'd3);
    add_seed(64'hDEAD_BEEF_0000_0001);
    drain();
    cfg_write(CFG_GREASE, 3'd4);
    add_seed(64'hFEDC_BA98_7654_3210);
    add_seed(64'd0);
    drain();

    // random phases across settings
    set_profile(3'd1, 3'd2, 3'd2, 3'd1, 3'd1);
    random_seeds(25);
    drain();
    set_profile(3'd1, 3'd1, 3'd3, 3'd0, 3'd0);
    random_seeds(25);
    drain();
    set_profile(3'd1, 3'd3, 3'd4, 3'd0, 3'd1);
    random_seeds(20);
    drain();
    set_profile(3'd0, 3'd0, 3'd3, 3'd1, 3'd0);
    random_seeds(20);
    drain();

    // last stretch at full rate, no idling on either side
    set_profile(3'd1, 3'd0, 3'd2, 3'd1, 3'd0);
    idle_on = 1'b0;
    random_seeds(20);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
